FILE: sv/prd_pkg.sv
package prd_pkg;

    // Default sizes of the three rings
    localparam int WINDOW_DEF = 20;
    localparam int LAG_DEF    = 10;
    localparam int BEATS_DEF  = 60;

    // Field widths
    localparam int SAMPLE_W  = 10;
    localparam int SAMPLE_MAX = 1023;
    localparam int TS_W      = 32;
    localparam int IV_W      = 16;
    localparam int BPM_W     = 8;
    localparam int WSUM_W    = 15;
    localparam int MARGIN_W  = 10;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP       = 2'd3;

    // Configuration reset values
    localparam logic [IV_W-1:0]     REFRACTORY_RST = 16'd300;
    localparam logic [IV_W-1:0]     MIN_VALID_RST  = 16'd300;
    localparam logic [IV_W-1:0]     MAX_VALID_RST  = 16'd2000;
    localparam logic [MARGIN_W-1:0] DROP_RST       = 10'd1;

    // Milliseconds per minute, dividend of the rate
    localparam int MINUTE_MS = 60000;
    localparam logic [BPM_W-1:0] BPM_SAT = 8'd255;

    // Command from the detector to the rate unit
    typedef struct packed {
        logic            start;
        logic [IV_W-1:0] interval;
        logic [IV_W-1:0] min_ms;
        logic [IV_W-1:0] max_ms;
    } t_rate_cmd;

    // Status from the rate unit
    typedef struct packed {
        logic             busy;
        logic [BPM_W-1:0] bpm;
    } t_rate_sts;

endpackage

FILE: sv/prd_ram.sv
module prd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/prd_div.sv
module prd_div #(
    parameter int W = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_dvs;

    logic [W:0]    w_shift;
    logic [W+1:0]  w_diff;
    logic          w_ge;

    // One restoring step: shift in next dividend bit, try subtract
    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_ge    = !w_diff[W+1];

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[W-1:0] : w_shift[W-1:0];
            r_quo <= {r_quo[W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: sv/prd_rate.sv
module prd_rate #(
    parameter int BEATS = prd_pkg::BEATS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prd_pkg::t_rate_cmd i_cmd,
    output prd_pkg::t_rate_sts o_sts
);

    localparam int IPTR_W  = (BEATS > 1) ? $clog2(BEATS) : 1;
    localparam int CNT_W   = $clog2(BEATS + 1);
    localparam int TOTAL_W = $clog2(BEATS * 65535 + 1);

    localparam logic [2:0] R_IDLE  = 3'd0;
    localparam logic [2:0] R_SWEEP = 3'd1;
    localparam logic [2:0] R_MEAN  = 3'd2;
    localparam logic [2:0] R_DIV1  = 3'd3;
    localparam logic [2:0] R_DIV2  = 3'd4;

    logic [2:0]                r_state;
    logic [IPTR_W-1:0]         r_iptr;
    logic                      r_full;
    logic [CNT_W-1:0]          r_idx;
    logic                      r_pend;
    logic                      r_pend_ok;
    logic [TOTAL_W-1:0]        r_total;
    logic [CNT_W-1:0]          r_count;
    logic [prd_pkg::BPM_W-1:0] r_bpm;

    logic                      w_we;
    logic [prd_pkg::IV_W-1:0]  w_rdata;
    logic                      w_in_range;
    logic                      w_div_start;
    logic [TOTAL_W-1:0]        w_div_a;
    logic [TOTAL_W-1:0]        w_div_b;
    logic                      w_div_done;
    logic [TOTAL_W-1:0]        w_div_q;

    // Interval ring
    assign w_we = (r_state == R_IDLE) && i_cmd.start;

    prd_ram #(
        .WIDTH (prd_pkg::IV_W),
        .DEPTH (BEATS)
    ) u_iv_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_iptr),
        .i_wdata (i_cmd.interval),
        .i_raddr (r_idx[IPTR_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_in_range = r_pend_ok && (w_rdata > i_cmd.min_ms) && (w_rdata < i_cmd.max_ms);

    // Shared divider: mean first, then minute / mean
    assign w_div_start = ((r_state == R_MEAN) && (r_count != '0)) ||
                         ((r_state == R_DIV1) && w_div_done && (w_div_q != '0));
    assign w_div_a = (r_state == R_DIV1) ? TOTAL_W'(prd_pkg::MINUTE_MS) : r_total;
    assign w_div_b = (r_state == R_DIV1) ? w_div_q : TOTAL_W'(r_count);

    prd_div #(
        .W (TOTAL_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_iptr  <= '0;
            r_full  <= 1'b0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_bpm   <= '0;
        end else begin
            case (r_state)
                R_IDLE: begin
                    if (i_cmd.start) begin
                        if (r_iptr == IPTR_W'(BEATS - 1)) begin
                            r_iptr <= '0;
                            r_full <= 1'b1;
                        end else begin
                            r_iptr <= r_iptr + 1'b1;
                        end
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= R_SWEEP;
                    end
                end
                R_SWEEP: begin
                    if (r_idx != CNT_W'(BEATS)) begin
                        r_idx  <= r_idx + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= R_MEAN;
                        end
                    end
                end
                R_MEAN: begin
                    r_state <= (r_count == '0) ? R_IDLE : R_DIV1;
                end
                R_DIV1: begin
                    if (w_div_done) begin
                        r_state <= (w_div_q == '0) ? R_IDLE : R_DIV2;
                    end
                end
                R_DIV2: begin
                    if (w_div_done) begin
                        r_bpm   <= (w_div_q > TOTAL_W'(prd_pkg::BPM_SAT)) ?
                                   prd_pkg::BPM_SAT : w_div_q[prd_pkg::BPM_W-1:0];
                        r_state <= R_IDLE;
                    end
                end
                default: begin
                    r_state <= R_IDLE;
                end
            endcase
        end
    end

    // Sweep accumulators; entries never written are skipped
    always_ff @(posedge i_clk) begin
        if (r_state == R_IDLE) begin
            r_total <= '0;
            r_count <= '0;
        end else if (r_state == R_SWEEP) begin
            r_pend_ok <= r_full || (r_idx < CNT_W'(r_iptr));
            if (r_pend && w_in_range) begin
                r_total <= r_total + TOTAL_W'(w_rdata);
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_sts.busy = (r_state != R_IDLE);
    assign o_sts.bpm  = r_bpm;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(BEATS))
        else $error("valid interval count exceeds ring size");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == R_DIV1 || r_state == R_DIV2))
        else $error("divider finished outside a division step");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> r_state == R_IDLE)
        else $error("rate update started while busy");

endmodule

FILE: sv/pulse_rate_detector.sv
// A word accepted in ST_IDLE passes through ST_READ, ST_CMP and ST_DONE; a beat adds ST_WAIT
//   for the rate update (sweep of the interval ring plus up to two bit-serial divisions in
//   one shared divider). A new word is taken only in ST_IDLE, once the previous result has
//   been loaded into the output register; ST_DONE waits while the output is stalled.
// Reset is synchronous, active low: configuration returns to its defaults, the rings read
//   as zero until written (fill flags), no clearing pass is needed.
module pulse_rate_detector #(
    parameter int WINDOW = prd_pkg::WINDOW_DEF,
    parameter int LAG    = prd_pkg::LAG_DEF,
    parameter int BEATS  = prd_pkg::BEATS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [prd_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [prd_pkg::TS_W-1:0]       i_timestamp_ms,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [prd_pkg::WSUM_W-1:0]     o_window_sum,
    output logic                           o_beat,
    output logic [prd_pkg::IV_W-1:0]       o_last_interval_ms,
    output logic [prd_pkg::BPM_W-1:0]      o_beats_per_minute,
    input  logic                           i_cfg_we,
    input  logic [prd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [prd_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int SPTR_W = $clog2(WINDOW);
    localparam int HPTR_W = (LAG > 1) ? $clog2(LAG) : 1;
    localparam int SUM_W  = $clog2(WINDOW * prd_pkg::SAMPLE_MAX + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                    r_state;
    logic [SPTR_W-1:0]             r_sptr;
    logic                          r_s_full;
    logic [HPTR_W-1:0]             r_hptr;
    logic                          r_h_full;
    logic [SUM_W-1:0]              r_sum;
    logic [SUM_W-1:0]              r_lagged;
    logic [prd_pkg::SAMPLE_W-1:0]  r_sample;
    logic [prd_pkg::TS_W-1:0]      r_now;
    logic [prd_pkg::TS_W-1:0]      r_last_beat;
    logic [prd_pkg::IV_W-1:0]      r_recent;
    logic                          r_beat;

    logic [prd_pkg::IV_W-1:0]      r_refractory;
    logic [prd_pkg::IV_W-1:0]      r_min_valid;
    logic [prd_pkg::IV_W-1:0]      r_max_valid;
    logic [prd_pkg::MARGIN_W-1:0]  r_drop;
    logic [SUM_W-1:0]              r_drop_w;

    logic                          r_out_valid;
    logic [prd_pkg::WSUM_W-1:0]    r_out_sum;
    logic                          r_out_beat;
    logic [prd_pkg::IV_W-1:0]      r_out_iv;
    logic [prd_pkg::BPM_W-1:0]     r_out_bpm;

    logic                          w_accept;
    logic                          w_step;
    logic [prd_pkg::SAMPLE_W-1:0]  w_s_rdata;
    logic [SUM_W-1:0]              w_h_rdata;
    logic [SUM_W-1:0]              w_old;
    logic [SUM_W-1:0]              w_lagged;
    logic [SUM_W-1:0]              n_sum;
    logic                          w_drop;
    logic [prd_pkg::TS_W-1:0]      w_elapsed;
    logic                          w_late;
    logic                          w_beat;
    logic [prd_pkg::IV_W-1:0]      w_iv;
    logic                          w_load;
    prd_pkg::t_rate_cmd            w_rate_cmd;
    prd_pkg::t_rate_sts            w_rate_sts;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_step     = (r_state == ST_READ);

    // Sample ring and lagged-sum ring
    prd_ram #(
        .WIDTH (prd_pkg::SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_step),
        .i_waddr (r_sptr),
        .i_wdata (r_sample),
        .i_raddr (r_sptr),
        .o_rdata (w_s_rdata)
    );

    prd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (LAG)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_step),
        .i_waddr (r_hptr),
        .i_wdata (n_sum),
        .i_raddr (r_hptr),
        .o_rdata (w_h_rdata)
    );

    // Read-modify-write of the running sum; unwritten entries read as zero
    assign w_old    = r_s_full ? SUM_W'(w_s_rdata) : '0;
    assign w_lagged = r_h_full ? w_h_rdata : '0;
    assign n_sum    = r_sum - w_old + SUM_W'(r_sample);

    // Beat test on sums, refractory test on wrapped elapsed time
    assign w_drop    = ({1'b0, r_sum} + {1'b0, r_drop_w}) < {1'b0, r_lagged};
    assign w_elapsed = r_now - r_last_beat;
    assign w_late    = w_elapsed > prd_pkg::TS_W'(r_refractory);
    assign w_beat    = w_drop && w_late;
    assign w_iv      = (|w_elapsed[prd_pkg::TS_W-1:prd_pkg::IV_W]) ? '1 :
                       w_elapsed[prd_pkg::IV_W-1:0];

    assign w_rate_cmd.start    = (r_state == ST_CMP) && w_beat;
    assign w_rate_cmd.interval = w_iv;
    assign w_rate_cmd.min_ms   = r_min_valid;
    assign w_rate_cmd.max_ms   = r_max_valid;

    prd_rate #(
        .BEATS (BEATS)
    ) u_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_rate_cmd),
        .o_sts   (w_rate_sts)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refractory <= prd_pkg::REFRACTORY_RST;
            r_min_valid  <= prd_pkg::MIN_VALID_RST;
            r_max_valid  <= prd_pkg::MAX_VALID_RST;
            r_drop       <= prd_pkg::DROP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                prd_pkg::CFG_REFRACTORY: r_refractory <= i_cfg_data;
                prd_pkg::CFG_MIN_VALID:  r_min_valid  <= i_cfg_data;
                prd_pkg::CFG_MAX_VALID:  r_max_valid  <= i_cfg_data;
                prd_pkg::CFG_DROP:       r_drop       <= i_cfg_data[prd_pkg::MARGIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Margin scaled to a sum, precomputed while configuration is stable
    always_ff @(posedge i_clk) begin
        r_drop_w <= SUM_W'(SUM_W'(r_drop) * SUM_W'(WINDOW));
    end

    // Control sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sptr      <= '0;
            r_s_full    <= 1'b0;
            r_hptr      <= '0;
            r_h_full    <= 1'b0;
            r_sum       <= '0;
            r_last_beat <= '0;
            r_recent    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_sum <= n_sum;
                    if (r_sptr == SPTR_W'(WINDOW - 1)) begin
                        r_sptr   <= '0;
                        r_s_full <= 1'b1;
                    end else begin
                        r_sptr <= r_sptr + 1'b1;
                    end
                    if (r_hptr == HPTR_W'(LAG - 1)) begin
                        r_hptr   <= '0;
                        r_h_full <= 1'b1;
                    end else begin
                        r_hptr <= r_hptr + 1'b1;
                    end
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (w_beat) begin
                        r_last_beat <= r_now;
                        r_recent    <= w_iv;
                        r_state     <= ST_WAIT;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_WAIT: begin
                    if (!w_rate_sts.busy) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign w_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample;
            r_now    <= i_timestamp_ms;
        end
        if (w_step) begin
            r_lagged <= w_lagged;
        end
        if (r_state == ST_CMP) begin
            r_beat <= w_beat;
        end
        if (w_load) begin
            r_out_sum  <= prd_pkg::WSUM_W'(r_sum);
            r_out_beat <= r_beat;
            r_out_iv   <= r_recent;
            r_out_bpm  <= w_rate_sts.bpm;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_window_sum       = r_out_sum;
    assign o_beat             = r_out_beat;
    assign o_last_interval_ms = r_out_iv;
    assign o_beats_per_minute = r_out_bpm;

    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ST_READ)
        else $error("accepted word did not start a ring update");

    a_rate_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_READ) |-> !w_rate_sts.busy)
        else $error("rate unit busy while a new word is taken");

    a_sptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sptr <= SPTR_W'(WINDOW - 1))
        else $error("sample pointer out of ring");

    a_beat_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_beat) |-> o_last_interval_ms != '0)
        else $error("beat reported with zero interval");

endmodule

FILE: dv/pulse_rate_detector_tb.sv
`timescale 1ns / 1ps

module pulse_rate_detector_tb;

    localparam int WINDOW = prd_pkg::WINDOW_DEF;
    localparam int LAG    = prd_pkg::LAG_DEF;
    localparam int BEATS  = prd_pkg::BEATS_DEF;

    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 140;
    localparam int STALL_LEN   = 400;
    localparam int TAIL_CYCLES = 150;

    // One sample word and one result word
    typedef struct packed {
        logic [prd_pkg::SAMPLE_W-1:0] sample;
        logic [prd_pkg::TS_W-1:0]     ts;
    } t_ppg_word;

    typedef struct packed {
        logic [prd_pkg::WSUM_W-1:0] window_sum;
        logic                       beat;
        logic [prd_pkg::IV_W-1:0]   last_interval;
        logic [prd_pkg::BPM_W-1:0]  bpm;
    } t_beat_word;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_ready;
    logic [prd_pkg::SAMPLE_W-1:0]  i_sample       = '0;
    logic [prd_pkg::TS_W-1:0]      i_timestamp_ms = '0;
    logic                          o_out_valid;
    logic                          i_out_ready    = 1'b0;
    logic [prd_pkg::WSUM_W-1:0]    o_window_sum;
    logic                          o_beat;
    logic [prd_pkg::IV_W-1:0]      o_last_interval_ms;
    logic [prd_pkg::BPM_W-1:0]     o_beats_per_minute;
    logic                          i_cfg_we       = 1'b0;
    logic [prd_pkg::CFG_IDX_W-1:0] i_cfg_index    = prd_pkg::CFG_REFRACTORY;
    logic [prd_pkg::CFG_W-1:0]     i_cfg_data     = '0;

    pulse_rate_detector #(
        .WINDOW (WINDOW),
        .LAG    (LAG),
        .BEATS  (BEATS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_sample           (i_sample),
        .i_timestamp_ms     (i_timestamp_ms),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_window_sum       (o_window_sum),
        .o_beat             (o_beat),
        .o_last_interval_ms (o_last_interval_ms),
        .o_beats_per_minute (o_beats_per_minute),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Detector state as the testbench tracks it
    logic [prd_pkg::IV_W-1:0]     cfg_refractory;
    logic [prd_pkg::IV_W-1:0]     cfg_min_valid;
    logic [prd_pkg::IV_W-1:0]     cfg_max_valid;
    logic [prd_pkg::MARGIN_W-1:0] cfg_drop;

    logic [prd_pkg::SAMPLE_W-1:0] win_samples [WINDOW];
    int unsigned                  win_ptr;
    int unsigned                  win_sum;
    int unsigned                  lag_sums [LAG];
    int unsigned                  lag_ptr;
    logic [prd_pkg::IV_W-1:0]     beat_intervals [BEATS];
    int unsigned                  iv_ptr;
    logic [prd_pkg::TS_W-1:0]     last_beat_ts;
    logic [prd_pkg::IV_W-1:0]     recent_iv;
    logic [prd_pkg::BPM_W-1:0]    cur_bpm;

    t_ppg_word  sample_words[$];
    t_beat_word expected_words[$];
    logic [prd_pkg::TS_W-1:0] ts_now;

    int n_queued     = 0;
    int n_accepted   = 0;
    int n_results    = 0;
    int n_beats      = 0;
    int n_sat_iv     = 0;
    int n_max_bpm    = 0;
    int n_errors     = 0;
    int n_settings   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int stall_served   = 0;
    int stall_left     = 0;

    // Mean of the in-range intervals over the whole ring, then 60000 / mean
    function automatic void recompute_bpm();
        int unsigned total;
        int unsigned count;
        int unsigned mean;
        int unsigned q;
        total = 0;
        count = 0;
        for (int i = 0; i < BEATS; i++) begin
            if (beat_intervals[i] > cfg_min_valid && beat_intervals[i] < cfg_max_valid) begin
                total += beat_intervals[i];
                count++;
            end
        end
        if (count != 0) begin
            mean = total / count;
            if (mean != 0) begin
                q = prd_pkg::MINUTE_MS / mean;
                cur_bpm = (q > prd_pkg::BPM_SAT) ? prd_pkg::BPM_SAT : q[prd_pkg::BPM_W-1:0];
            end
        end
    endfunction

    // Advance the tracked state by one sample word and return its result
    function automatic t_beat_word predict_pulse_word(logic [prd_pkg::SAMPLE_W-1:0] smp,
                                                      logic [prd_pkg::TS_W-1:0] now);
        t_beat_word               r;
        int unsigned              lagged;
        logic [prd_pkg::TS_W-1:0] elapsed;
        logic [prd_pkg::IV_W-1:0] iv;
        win_sum = win_sum - win_samples[win_ptr] + smp;
        win_samples[win_ptr] = smp;
        win_ptr = (win_ptr + 1 >= WINDOW) ? 0 : win_ptr + 1;

        lagged = lag_sums[lag_ptr];
        lag_sums[lag_ptr] = win_sum;
        lag_ptr = (lag_ptr + 1 >= LAG) ? 0 : lag_ptr + 1;

        r.beat = 1'b0;
        // averages compared as sums; elapsed time wraps mod 2^32
        if (win_sum + cfg_drop * WINDOW < lagged) begin
            elapsed = now - last_beat_ts;
            if (elapsed > cfg_refractory) begin
                iv = (elapsed > 32'd65535) ? 16'hFFFF : elapsed[prd_pkg::IV_W-1:0];
                r.beat = 1'b1;
                beat_intervals[iv_ptr] = iv;
                iv_ptr = (iv_ptr + 1 >= BEATS) ? 0 : iv_ptr + 1;
                recent_iv = iv;
                last_beat_ts = now;
                recompute_bpm();
            end
        end
        r.window_sum    = win_sum[prd_pkg::WSUM_W-1:0];
        r.last_interval = recent_iv;
        r.bpm           = cur_bpm;
        return r;
    endfunction

    function automatic void clear_tracked_state();
        cfg_refractory = prd_pkg::REFRACTORY_RST;
        cfg_min_valid  = prd_pkg::MIN_VALID_RST;
        cfg_max_valid  = prd_pkg::MAX_VALID_RST;
        cfg_drop       = prd_pkg::DROP_RST;
        foreach (win_samples[i]) win_samples[i] = '0;
        foreach (lag_sums[i]) lag_sums[i] = 0;
        foreach (beat_intervals[i]) beat_intervals[i] = '0;
        win_ptr      = 0;
        win_sum      = 0;
        lag_ptr      = 0;
        iv_ptr       = 0;
        last_beat_ts = '0;
        recent_iv    = '0;
        cur_bpm      = '0;
    endfunction

    // Sender: predicts on each accepted word, then offers the next one
    always @(posedge i_clk) begin : driver
        t_ppg_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_words.push_back(predict_pulse_word(i_sample, i_timestamp_ms));
                n_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (sample_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = sample_words.pop_front();
                    i_in_valid     <= 1'b1;
                    i_sample       <= w.sample;
                    i_timestamp_ms <= w.ts;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off, counted here
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_served != stall_requests) begin
            stall_left   <= STALL_LEN;
            stall_served <= stall_served + 1;
        end
    end

    // Receiver: checks each result word against the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_beat_word exp_r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no sample outstanding");
                    n_errors++;
                end else begin
                    exp_r = expected_words.pop_front();
                    n_results++;
                    if (exp_r.beat) n_beats++;
                    if (exp_r.beat && exp_r.last_interval == 16'hFFFF) n_sat_iv++;
                    if (exp_r.bpm == prd_pkg::BPM_SAT) n_max_bpm++;
                    if (o_window_sum !== exp_r.window_sum) begin
                        $error("window_sum expected %0d got %0d", exp_r.window_sum, o_window_sum);
                        n_errors++;
                    end
                    if (o_beat !== exp_r.beat) begin
                        $error("beat expected %0d got %0d", exp_r.beat, o_beat);
                        n_errors++;
                    end
                    if (o_last_interval_ms !== exp_r.last_interval) begin
                        $error("last_interval_ms expected %0d got %0d",
                               exp_r.last_interval, o_last_interval_ms);
                        n_errors++;
                    end
                    if (o_beats_per_minute !== exp_r.bpm) begin
                        $error("beats_per_minute expected %0d got %0d",
                               exp_r.bpm, o_beats_per_minute);
                        n_errors++;
                    end
                end
            end
            i_out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_word(logic [prd_pkg::SAMPLE_W-1:0] smp, logic [prd_pkg::TS_W-1:0] ts);
        t_ppg_word w;
        w.sample = smp;
        w.ts     = ts;
        sample_words.push_back(w);
        n_queued++;
    endtask

    task automatic write_cfg(logic [prd_pkg::CFG_IDX_W-1:0] idx,
                             logic [prd_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            prd_pkg::CFG_REFRACTORY: cfg_refractory = data;
            prd_pkg::CFG_MIN_VALID:  cfg_min_valid  = data;
            prd_pkg::CFG_MAX_VALID:  cfg_max_valid  = data;
            prd_pkg::CFG_DROP:       cfg_drop       = data[prd_pkg::MARGIN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [prd_pkg::IV_W-1:0] refr,
                                  logic [prd_pkg::IV_W-1:0] minv,
                                  logic [prd_pkg::IV_W-1:0] maxv,
                                  logic [prd_pkg::MARGIN_W-1:0] drop);
        write_cfg(prd_pkg::CFG_REFRACTORY, refr);
        write_cfg(prd_pkg::CFG_MIN_VALID, minv);
        write_cfg(prd_pkg::CFG_MAX_VALID, maxv);
        write_cfg(prd_pkg::CFG_DROP, prd_pkg::CFG_W'(drop));
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Block until every queued word is in and every result is out
    task automatic wait_idle();
        do @(posedge i_clk);
        while (n_accepted != n_queued || expected_words.size() != 0);
    endtask

    // Mostly pulse trains with random shape, some noise bursts and odd timestamps
    task automatic queue_phase(int n);
        int left;
        int len;
        int period;
        int rise;
        int dt;
        int amp;
        int base;
        int nz;
        int p;
        int v;
        left = n;
        while (left > 0) begin
            if ($urandom_range(99) < 80) begin
                len = $urandom_range(40, 160);
                if (len > left) len = left;
                period = $urandom_range(20, 90);
                rise   = period / 4;
                dt     = $urandom_range(2, 25);
                amp    = $urandom_range(40, 600);
                base   = $urandom_range(0, prd_pkg::SAMPLE_MAX - amp);
                nz     = $urandom_range(0, amp / 10);
                for (int k = 0; k < len; k++) begin
                    p = k % period;
                    if (p < rise) v = base + (amp * p) / rise;
                    else v = base + amp - (amp * (p - rise)) / (period - rise);
                    v = v + int'($urandom_range(0, 2 * nz)) - nz;
                    if (v < 0) v = 0;
                    if (v > prd_pkg::SAMPLE_MAX) v = prd_pkg::SAMPLE_MAX;
                    ts_now += dt;
                    push_word(prd_pkg::SAMPLE_W'(v), ts_now);
                end
            end else begin
                len = $urandom_range(2, 12);
                if (len > left) len = left;
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 5))
                        0: ts_now = $urandom();
                        1: ts_now -= $urandom_range(1, 5000);
                        2: ;
                        3: ts_now += $urandom_range(60000, 200000);
                        default: ts_now += $urandom_range(1, 400);
                    endcase
                    push_word(prd_pkg::SAMPLE_W'($urandom_range(0, prd_pkg::SAMPLE_MAX)), ts_now);
                end
            end
            left -= len;
        end
    endtask

    initial begin : stimulus
        logic [prd_pkg::IV_W-1:0] minv;
        int                       maxv;
        clear_tracked_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings
        send_idle_pct = 31;
        recv_idle_pct = 49;
        // no beat while the lag history is still zero; extreme samples
        for (int k = 0; k < 5; k++) begin
            push_word(prd_pkg::SAMPLE_W'(prd_pkg::SAMPLE_MAX), prd_pkg::TS_W'(k * 5));
        end
        for (int k = 5; k < 20; k++) push_word(0, prd_pkg::TS_W'(k * 5));
        push_word(0, 32'h0001_2345);          // first beat timed from zero, saturated
        push_word(0, 32'h0001_233B);          // time goes backwards: long wait
        push_word(0, 32'hFFFF_FFFF);
        push_word(0, 32'd499);                // wraps to a 500 ms interval
        push_word(prd_pkg::SAMPLE_W'(prd_pkg::SAMPLE_MAX), 32'd500);  // inside the refractory time
        push_word(prd_pkg::SAMPLE_W'(prd_pkg::SAMPLE_MAX), 32'd800);  // just past it
        push_word(10'd512, 32'd1100);         // exactly at it: no beat
        ts_now = 32'd1100;
        wait_idle();

        // Random phases, each under its own register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_settings(16'd0, 16'd0, 16'hFFFF, 10'd0);       // rate saturates
                1: apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 10'd1023); // nothing passes
                2: apply_settings(16'd300, 16'd1000, 16'd1000, 10'd1);  // empty range
                3: apply_settings(prd_pkg::REFRACTORY_RST, prd_pkg::MIN_VALID_RST,
                                  prd_pkg::MAX_VALID_RST, prd_pkg::DROP_RST);
                default: begin
                    minv = prd_pkg::IV_W'($urandom_range(0, 700));
                    maxv = minv + $urandom_range(200, 3000);
                    apply_settings(prd_pkg::IV_W'($urandom_range(0, 700)), minv,
                                   prd_pkg::IV_W'(maxv),
                                   prd_pkg::MARGIN_W'((ph == 10) ? $urandom_range(0, 40) :
                                                                   $urandom_range(0, 6)));
                end
            endcase
            case (ph / 4)
                0: begin send_idle_pct = 31; recv_idle_pct = 49; end
                1: begin send_idle_pct = 49; recv_idle_pct = 31; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            // hold the output off long enough to back up the input
            if (ph == 9) stall_requests++;
            queue_phase(PHASE_WORDS);
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("pulse_rate_detector_tb: %0d samples, %0d results, %0d beats", n_accepted,
                 n_results, n_beats);
        $display("pulse_rate_detector_tb: %0d saturated intervals, %0d at top rate, %0d settings",
                 n_sat_iv, n_max_bpm, n_settings + 1);
        if (n_errors == 0) begin
            $display("pulse_rate_detector_tb: done, clean");
        end else begin
            $display("pulse_rate_detector_tb: done, errors");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #30_000_000;
        $display("pulse_rate_detector_tb: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
sv/prd_pkg.sv
sv/prd_ram.sv
sv/prd_div.sv
sv/prd_rate.sv
sv/pulse_rate_detector.sv
dv/pulse_rate_detector_tb.sv
